[src/tli_pkg.sv]
// Shared types and constants for the table linear interpolator.
`default_nettype none

package tli_pkg;

  localparam int MAX_POINTS = 256;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int X_W        = 32;
  localparam int Y_W        = 32;
  localparam int NP_W       = 9;
  localparam int IDX_W      = 8;

  // The multiply-divide loop walks the 33 magnitude bits of y(i+1) - y(i).
  localparam int MAG_W      = Y_W + 1;
  localparam int DIV_STEPS  = MAG_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [NP_W-1:0] NP_RESET = NP_W'(2);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] RS_INSIDE = 2'd0;
  localparam logic [1:0] RS_BELOW  = 2'd1;
  localparam logic [1:0] RS_ABOVE  = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } tli_state_t;

  typedef struct packed {
    logic q_start;
    logic addr_inc;
    logic take_first;
    logic take_prev;
    logic take_seg;
    logic div_step;
    logic emit_seg;
    logic emit_miss;
  } tli_cmd_t;

  typedef struct packed {
    logic seg_hit;
    logic scan_last;
    logic div_last;
  } tli_stat_t;

endpackage

`default_nettype wire

[src/tli_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/tli_ctrl.sv]
// Sequencing state machine for breakpoint scan, multiply-divide and result issue.
`default_nettype none

module tli_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              query_go,
  input  wire tli_pkg::tli_stat_t stat,
  output tli_pkg::tli_cmd_t      cmd,
  output logic                   busy
);

  tli_pkg::tli_state_t state_r;
  tli_pkg::tli_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tli_pkg::ST_IDLE: begin
        if (query_go) begin
          state_nxt = tli_pkg::ST_PRIME;
        end
      end
      tli_pkg::ST_PRIME: state_nxt = tli_pkg::ST_FIRST;
      tli_pkg::ST_FIRST: state_nxt = tli_pkg::ST_SCAN;
      tli_pkg::ST_SCAN: begin
        priority if (stat.seg_hit) begin
          state_nxt = tli_pkg::ST_DIV;
        end else if (stat.scan_last) begin
          state_nxt = tli_pkg::ST_IDLE;
        end
      end
      tli_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = tli_pkg::ST_DONE;
        end
      end
      tli_pkg::ST_DONE: state_nxt = tli_pkg::ST_IDLE;
      default: state_nxt = tli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != tli_pkg::ST_IDLE);
    unique case (state_r)
      tli_pkg::ST_IDLE: cmd.q_start = query_go;
      tli_pkg::ST_PRIME: cmd.addr_inc = 1'b1;
      tli_pkg::ST_FIRST: begin
        cmd.take_first = 1'b1;
        cmd.addr_inc   = 1'b1;
      end
      tli_pkg::ST_SCAN: begin
        // A matching segment wins even on the last entry.
        priority if (stat.seg_hit) begin
          cmd.take_seg = 1'b1;
        end else if (stat.scan_last) begin
          cmd.emit_miss = 1'b1;
        end else begin
          cmd.take_prev = 1'b1;
          cmd.addr_inc  = 1'b1;
        end
      end
      tli_pkg::ST_DIV: cmd.div_step = 1'b1;
      tli_pkg::ST_DONE: cmd.emit_seg = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/tli_dp.sv]
// Datapath: breakpoint tables, scan registers, multiply-divide unit and result register.
`default_nettype none

module tli_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load_we,
  input  wire logic [tli_pkg::IDX_W-1:0]   in_point_index,
  input  wire logic [tli_pkg::X_W-1:0]     in_x_in,
  input  wire logic signed [tli_pkg::Y_W-1:0] in_y_in,
  input  wire logic                        cfg_we,
  input  wire logic [tli_pkg::NP_W-1:0]    cfg_wdata,
  input  wire tli_pkg::tli_cmd_t           cmd,
  output tli_pkg::tli_stat_t               stat,
  output logic                             out_valid,
  output logic signed [tli_pkg::Y_W-1:0]   out_y_out,
  output logic [1:0]                       out_range_status
);

  logic [tli_pkg::NP_W-1:0]  num_points_r;
  logic [tli_pkg::X_W-1:0]   xq_r;
  tli_pkg::ptr_t             n_last_r;
  tli_pkg::ptr_t             n_last_nxt;
  tli_pkg::ptr_t             addr_r;
  logic [tli_pkg::X_W-1:0]   x0_r;
  logic [tli_pkg::Y_W-1:0]   y0_r;
  logic [tli_pkg::X_W-1:0]   prev_x_r;
  logic [tli_pkg::Y_W-1:0]   prev_y_r;
  logic [tli_pkg::X_W-1:0]   t_r;
  logic [tli_pkg::X_W-1:0]   dx_r;
  logic [tli_pkg::MAG_W-1:0] mag_r;
  logic [tli_pkg::MAG_W-1:0] mag_nxt;
  logic                      neg_r;
  logic [tli_pkg::Y_W-1:0]   ys_r;
  logic [tli_pkg::X_W-1:0]   rem_r;
  logic [tli_pkg::X_W-1:0]   rem_nxt;
  logic [tli_pkg::MAG_W-1:0] quo_r;
  logic [tli_pkg::MAG_W-1:0] quo_nxt;
  logic [tli_pkg::DCNT_W-1:0] cnt_r;
  logic                      out_valid_r;
  logic [tli_pkg::Y_W-1:0]   out_y_r;
  logic [tli_pkg::Y_W-1:0]   out_y_nxt;
  logic [1:0]                out_rs_r;
  logic [1:0]                out_rs_nxt;

  logic [tli_pkg::X_W-1:0]   x_rd;
  logic [tli_pkg::Y_W-1:0]   y_rd;
  logic                      ram_we;

  logic [tli_pkg::MAG_W-1:0] dy_up;
  logic [tli_pkg::MAG_W-1:0] dy_dn;

  logic [tli_pkg::X_W+1:0]   div_s;
  logic [tli_pkg::X_W+1:0]   div_d1;
  logic [tli_pkg::X_W+1:0]   div_d2;
  logic [tli_pkg::X_W+1:0]   div_m1;
  logic [tli_pkg::X_W+1:0]   div_m2;
  logic [1:0]                digit;

  logic [tli_pkg::Y_W+2:0]   y0_ext;
  logic [tli_pkg::Y_W+2:0]   q_ext;
  logic [tli_pkg::Y_W+2:0]   sum;

  assign ram_we = load_we && (32'(in_point_index) < tli_pkg::MAX_POINTS);

  tli_ram #(
    .WIDTH (tli_pkg::X_W),
    .DEPTH (tli_pkg::MAX_POINTS)
  ) u_x_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tli_pkg::ptr_t'(in_point_index)),
    .wdata (in_x_in),
    .raddr (addr_r),
    .rdata (x_rd)
  );

  tli_ram #(
    .WIDTH (tli_pkg::Y_W),
    .DEPTH (tli_pkg::MAX_POINTS)
  ) u_y_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tli_pkg::ptr_t'(in_point_index)),
    .wdata (in_y_in),
    .raddr (addr_r),
    .rdata (y_rd)
  );

  // Clamp the point count into the supported range and keep the last index.
  always_comb begin
    priority if (num_points_r < tli_pkg::NP_W'(2)) begin
      n_last_nxt = tli_pkg::ptr_t'(1);
    end else if (32'(num_points_r) > tli_pkg::MAX_POINTS) begin
      n_last_nxt = tli_pkg::ptr_t'(tli_pkg::MAX_POINTS - 1);
    end else begin
      n_last_nxt = tli_pkg::ptr_t'(num_points_r - tli_pkg::NP_W'(1));
    end
  end

  // The read data holds entry addr_r - 1 while scanning.
  assign stat.seg_hit   = (prev_x_r <= xq_r) && (xq_r < x_rd);
  assign stat.scan_last = ((addr_r - tli_pkg::ptr_t'(1)) == n_last_r);
  assign stat.div_last  = (cnt_r == tli_pkg::DCNT_W'(tli_pkg::DIV_STEPS - 1));

  assign dy_up   = {y_rd[tli_pkg::Y_W-1], y_rd} - {prev_y_r[tli_pkg::Y_W-1], prev_y_r};
  assign dy_dn   = {prev_y_r[tli_pkg::Y_W-1], prev_y_r} - {y_rd[tli_pkg::Y_W-1], y_rd};
  assign mag_nxt = dy_up[tli_pkg::MAG_W-1] ? dy_dn : dy_up;

  // One step of floor(mag * t / dx), magnitude bits MSB first. Since t < dx the
  // partial remainder stays below dx, so each step needs a digit of 0, 1 or 2.
  always_comb begin
    div_s  = {1'b0, rem_r, 1'b0} + (mag_r[tli_pkg::MAG_W-1] ? {2'b00, t_r} : '0);
    div_d1 = {2'b00, dx_r};
    div_d2 = {1'b0, dx_r, 1'b0};
    div_m1 = div_s - div_d1;
    div_m2 = div_s - div_d2;
    priority if (div_s >= div_d2) begin
      digit   = 2'd2;
      rem_nxt = div_m2[tli_pkg::X_W-1:0];
    end else if (div_s >= div_d1) begin
      digit   = 2'd1;
      rem_nxt = div_m1[tli_pkg::X_W-1:0];
    end else begin
      digit   = 2'd0;
      rem_nxt = div_s[tli_pkg::X_W-1:0];
    end
    quo_nxt = {quo_r[tli_pkg::MAG_W-2:0], 1'b0} + {{(tli_pkg::MAG_W-2){1'b0}}, digit};
  end

  assign y0_ext = {{3{ys_r[tli_pkg::Y_W-1]}}, ys_r};
  assign q_ext  = {2'b00, quo_r};
  assign sum    = neg_r ? (y0_ext - q_ext) : (y0_ext + q_ext);

  always_comb begin
    out_y_nxt  = out_y_r;
    out_rs_nxt = out_rs_r;
    priority if (cmd.emit_seg) begin
      out_rs_nxt = tli_pkg::RS_INSIDE;
      priority if (!sum[tli_pkg::Y_W+2] && (sum[tli_pkg::Y_W+1:tli_pkg::Y_W-1] != 3'b000)) begin
        out_y_nxt = {1'b0, {(tli_pkg::Y_W-1){1'b1}}};
      end else if (sum[tli_pkg::Y_W+2] && (sum[tli_pkg::Y_W+1:tli_pkg::Y_W-1] != 3'b111)) begin
        out_y_nxt = {1'b1, {(tli_pkg::Y_W-1){1'b0}}};
      end else begin
        out_y_nxt = sum[tli_pkg::Y_W-1:0];
      end
    end else if (cmd.emit_miss) begin
      if (xq_r < x0_r) begin
        out_y_nxt  = y0_r;
        out_rs_nxt = tli_pkg::RS_BELOW;
      end else begin
        out_y_nxt  = '0;
        out_rs_nxt = tli_pkg::RS_ABOVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= tli_pkg::NP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_points_r <= cfg_wdata;
      end
      out_valid_r <= cmd.emit_seg | cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      xq_r     <= in_x_in;
      n_last_r <= n_last_nxt;
      addr_r   <= '0;
    end else if (cmd.addr_inc) begin
      addr_r <= addr_r + tli_pkg::ptr_t'(1);
    end

    if (cmd.take_first) begin
      x0_r <= x_rd;
      y0_r <= y_rd;
    end
    if (cmd.take_first || cmd.take_prev) begin
      prev_x_r <= x_rd;
      prev_y_r <= y_rd;
    end

    if (cmd.take_seg) begin
      t_r   <= xq_r - prev_x_r;
      dx_r  <= x_rd - prev_x_r;
      neg_r <= dy_up[tli_pkg::MAG_W-1];
      mag_r <= mag_nxt;
      ys_r  <= prev_y_r;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      mag_r <= {mag_r[tli_pkg::MAG_W-2:0], 1'b0};
      cnt_r <= cnt_r + tli_pkg::DCNT_W'(1);
    end

    out_y_r  <= out_y_nxt;
    out_rs_r <= out_rs_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_y_out        = out_y_r;
  assign out_range_status = out_rs_r;

endmodule

`default_nettype wire

[src/table_linear_interpolator_core.sv]
// Top level of the piecewise linear interpolator over a breakpoint table.
// Loads are taken only while busy is low, leave busy low and give no result.
// A query inside a segment strobes its result after the scan and the multiply-divide
// loop; one outside the table strobes once the scan reaches the clamped last entry.
// Busy drops with the strobe, so the next request can be taken in the strobe cycle.
// The scan reads one breakpoint per cycle from the x and y table read ports, then a
// 33-step multiply-divide loop forms the fraction. Synchronous active-low reset
// clears the controller, the strobe and num_points (to 2); table contents are kept.
`default_nettype none

module table_linear_interpolator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [tli_pkg::IDX_W-1:0]     in_point_index,
  input  wire logic [tli_pkg::X_W-1:0]       in_x_in,
  input  wire logic signed [tli_pkg::Y_W-1:0] in_y_in,
  input  wire logic                          cfg_we,
  input  wire logic [tli_pkg::NP_W-1:0]      cfg_wdata,
  output logic                               out_valid,
  output logic signed [tli_pkg::Y_W-1:0]     out_y_out,
  output logic [1:0]                         out_range_status
);

  tli_pkg::tli_cmd_t  cmd;
  tli_pkg::tli_stat_t stat;
  logic               query_go;
  logic               load_we;

  assign query_go = start && (in_command == tli_pkg::CMD_QUERY);
  assign load_we  = start && !busy && (in_command == tli_pkg::CMD_LOAD);

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .query_go (query_go),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tli_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_we          (load_we),
    .in_point_index   (in_point_index),
    .in_x_in          (in_x_in),
    .in_y_in          (in_y_in),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_y_out        (out_y_out),
    .out_range_status (out_range_status)
  );

endmodule

`default_nettype wire

[src/tli_checker.sv]
// Port-level checks of request and result timing for the interpolator core.
`default_nettype none

module tli_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          in_command,
  input wire logic [tli_pkg::IDX_W-1:0]     in_point_index,
  input wire logic [tli_pkg::X_W-1:0]       in_x_in,
  input wire logic signed [tli_pkg::Y_W-1:0] in_y_in,
  input wire logic                          cfg_we,
  input wire logic [tli_pkg::NP_W-1:0]      cfg_wdata,
  input wire logic                          out_valid,
  input wire logic signed [tli_pkg::Y_W-1:0] out_y_out,
  input wire logic [1:0]                    out_range_status
);

  // A query request taken while idle always raises busy.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == tli_pkg::CMD_QUERY) |=> busy)
    else $error("query request did not raise busy");

  // A load request leaves busy low and yields no result.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == tli_pkg::CMD_LOAD) |=> !busy && !out_valid)
    else $error("load request raised busy or produced a result");

  // The core releases busy exactly when it hands out the result.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result strobe");

  // Each result is a single-cycle strobe while the core is idle.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe overlapped busy or lasted more than one cycle");

  // Results with above-range status report zero.
  a_above_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_range_status == tli_pkg::RS_ABOVE) |-> (out_y_out == '0))
    else $error("above-range result is not zero");

endmodule

bind table_linear_interpolator_core tli_checker u_tli_checker (.*);

`default_nettype wire

[test/table_linear_interpolator_core_test.sv]
// Self-checking testbench for the table linear interpolator: directed rows, then random phases.
module table_linear_interpolator_core_test;
  import tli_pkg::*;

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic [1:0]            status;
  } answer_t;

  typedef struct packed {
    logic                  cmd;
    logic [IDX_W-1:0]      idx;
    logic [X_W-1:0]        x;
    logic signed [Y_W-1:0] y;
    logic                  typed;
    answer_t               want;
  } directed_row_t;

  localparam int NUM_DIRECTED    = 24;
  localparam int TARGET_REQUESTS = 1450;
  localparam int DRAIN_CYCLES    = 4;
  localparam int END_CYCLES      = MAX_POINTS + 64;
  localparam longint Y_MAX       = 64'sd2147483647;
  localparam longint Y_MIN       = -64'sd2147483648;
  localparam answer_t NO_ANSWER  = '0;

  // Fields: command, slot, x, y, typed-in flag, expected y, expected range status.
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    {CMD_LOAD,  8'd0,   32'd100,        32'h0001_0000, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_LOAD,  8'd1,   32'd200,        32'h0003_0000, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd0,          32'h0,         1'b1, 32'h0001_0000, RS_BELOW},
    {CMD_QUERY, 8'd0,   32'd99,         32'h0,         1'b1, 32'h0001_0000, RS_BELOW},
    {CMD_QUERY, 8'd0,   32'd100,        32'h0,         1'b1, 32'h0001_0000, RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd150,        32'h0,         1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd199,        32'h0,         1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd200,        32'h0,         1'b1, 32'h0,         RS_ABOVE},
    {CMD_QUERY, 8'd0,   32'hFFFF_FFFF,  32'h0,         1'b1, 32'h0,         RS_ABOVE},
    {CMD_LOAD,  8'd0,   32'd0,          32'h8000_0000, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_LOAD,  8'd1,   32'hFFFF_FFFF,  32'h7FFF_FFFF, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd0,          32'h0,         1'b1, 32'h8000_0000, RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'h7FFF_FFFF,  32'h0,         1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'hFFFF_FFFE,  32'h0,         1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'hFFFF_FFFF,  32'h0,         1'b1, 32'h0,         RS_ABOVE},
    {CMD_LOAD,  8'd0,   32'd0,          32'h7FFF_FFFF, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_LOAD,  8'd1,   32'hFFFF_FFFF,  32'h8000_0000, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'h8000_0000,  32'h0,         1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd1,          32'h0,         1'b0, 32'h0,         RS_INSIDE},
    {CMD_LOAD,  8'd0,   32'd500,        32'h0005_0000, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_LOAD,  8'd1,   32'd300,        32'h0007_0000, 1'b0, 32'h0,         RS_INSIDE},
    {CMD_QUERY, 8'd0,   32'd400,        32'h0,         1'b1, 32'h0005_0000, RS_BELOW},
    {CMD_QUERY, 8'd0,   32'd600,        32'h0,         1'b1, 32'h0,         RS_ABOVE},
    {CMD_LOAD,  8'd255, 32'hAAAA_5555,  32'h5555_AAAA, 1'b0, 32'h0,         RS_INSIDE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_command;
  logic [IDX_W-1:0]      in_point_index;
  logic [X_W-1:0]        in_x_in;
  logic signed [Y_W-1:0] in_y_in;
  logic                  cfg_we;
  logic [NP_W-1:0]       cfg_wdata;
  logic                  out_valid;
  logic signed [Y_W-1:0] out_y_out;
  logic [1:0]            out_range_status;

  // Shadow of the breakpoint table and the point count register.
  logic [X_W-1:0]        bp_x [MAX_POINTS];
  logic signed [Y_W-1:0] bp_y [MAX_POINTS];
  bit                    bp_loaded [MAX_POINTS];
  logic [NP_W-1:0]       np_shadow = NP_RESET;

  answer_t expected_answers [$];
  int      mismatch_count = 0;
  int      requests_sent  = 0;
  bit      steady_run     = 1'b0;

  table_linear_interpolator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_point_index   (in_point_index),
    .in_x_in          (in_x_in),
    .in_y_in          (in_y_in),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_y_out        (out_y_out),
    .out_range_status (out_range_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int points_active();
    int count;
    count = int'(np_shadow);
    if (count < 2) count = 2;
    if (count > MAX_POINTS) count = MAX_POINTS;
    return count;
  endfunction

  function automatic answer_t interpolate_at(input logic [X_W-1:0] xq);
    int          count;
    int          i;
    int          seg;
    bit          found;
    longint      y0;
    longint      dy;
    longint      res;
    logic [63:0] dx;
    logic [63:0] t;
    logic [63:0] mag;
    logic [63:0] q;
    answer_t     r;
    count = points_active();
    found = 1'b0;
    seg   = 0;
    for (i = 0; i + 1 < count; i++) begin
      if (!found && bp_x[i] <= xq && xq < bp_x[i+1]) begin
        seg   = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      // Anything not below the first x lands here, unordered tables included.
      if (xq < bp_x[0]) begin
        r.y      = bp_y[0];
        r.status = RS_BELOW;
      end else begin
        r.y      = '0;
        r.status = RS_ABOVE;
      end
      return r;
    end
    y0  = longint'(bp_y[seg]);
    dy  = longint'(bp_y[seg+1]) - y0;
    dx  = 64'(bp_x[seg+1]) - 64'(bp_x[seg]);
    t   = 64'(xq) - 64'(bp_x[seg]);
    mag = (dy < 0) ? 64'(-dy) : 64'(dy);
    // The product stays below 2**64, so unsigned 64-bit math is exact.
    q   = (dx != 0) ? (mag * t) / dx : 64'd0;
    res = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
    if (res > Y_MAX) res = Y_MAX;
    if (res < Y_MIN) res = Y_MIN;
    r.y      = res[Y_W-1:0];
    r.status = RS_INSIDE;
    return r;
  endfunction

  task automatic issue(input logic cmd, input logic [IDX_W-1:0] idx, input logic [X_W-1:0] x,
                       input logic signed [Y_W-1:0] y, input logic typed, input answer_t want);
    @(negedge clk);
    in_command     = cmd;
    in_point_index = idx;
    in_x_in        = x;
    in_y_in        = y;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (cmd == CMD_LOAD) begin
      bp_x[idx]      = x;
      bp_y[idx]      = y;
      bp_loaded[idx] = 1'b1;
    end else if (typed) begin
      expected_answers.push_back(want);
    end else begin
      expected_answers.push_back(interpolate_at(x));
    end
  endtask

  task automatic idle_sender();
    int gap;
    int pick;
    if (steady_run) begin
      gap = 0;
    end else begin
      pick = $urandom_range(99, 0);
      if (pick < 45) gap = 0;
      else if (pick < 92) gap = $urandom_range(3, 1);
      else gap = $urandom_range(60, 10);
    end
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [NP_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    np_shadow = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  always @(posedge clk) begin
    answer_t head;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result with no request pending: y_out %h, range_status %0d",
                 $time, out_y_out, out_range_status);
        mismatch_count++;
      end else begin
        head = expected_answers.pop_front();
        if (out_y_out !== head.y) begin
          $display("%0t: y_out expected %h, got %h", $time, head.y, out_y_out);
          mismatch_count++;
        end
        if (out_range_status !== head.status) begin
          $display("%0t: range_status expected %0d, got %0d",
                   $time, head.status, out_range_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #60000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int                    r;
    int                    i;
    int                    n;
    int                    phase;
    int                    queries;
    int                    pick;
    bit                    full_y;
    bit                    broken;
    bit                    full_reload;
    longint unsigned       cursor;
    longint unsigned       step_max;
    logic [NP_W-1:0]       np_value;
    logic [X_W-1:0]        xq;
    logic [X_W-1:0]        lo;
    logic [X_W-1:0]        hi;
    logic signed [Y_W-1:0] yv;
    directed_row_t         row;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_LOAD;
    in_point_index = '0;
    in_x_in        = '0;
    in_y_in        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED[r];
      issue(row.cmd, row.idx, row.x, row.y, row.typed, row.want);
      idle_sender();
    end

    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      drain_results();
      case (phase)
        0:       np_value = 9'd3;
        1:       np_value = 9'd256;
        2:       np_value = 9'd0;
        3:       np_value = 9'd511;
        4:       np_value = 9'd1;
        5:       np_value = 9'd2;
        6:       np_value = 9'd257;
        7:       np_value = 9'd64;
        default: np_value = ($urandom_range(9, 0) == 0) ? NP_W'($urandom_range(64, 13))
                                                       : NP_W'($urandom_range(12, 0));
      endcase
      set_point_count(np_value);
      n          = points_active();
      steady_run = ($urandom_range(3, 0) == 0);
      full_y     = ($urandom_range(2, 0) == 0);
      broken     = (n <= 64) && ($urandom_range(4, 0) == 0);

      // Large tables are rebuilt only until every slot in use holds a breakpoint.
      full_reload = (n <= 64);
      for (i = 0; i < n; i++) begin
        if (!bp_loaded[i]) full_reload = 1'b1;
      end
      if (full_reload) begin
        cursor   = ($urandom_range(1, 0) == 0) ? $urandom_range(1000, 0)
                                               : $urandom_range(32'h8000_0000, 0);
        step_max = (64'hFFFF_FFFF - cursor) / n;
        pick     = $urandom_range(2, 0);
        if (pick == 0 && step_max > 4) step_max = 4;
        if (pick == 1 && step_max > 1000) step_max = 1000;
        for (i = 0; i < n; i++) begin
          if (broken) begin
            xq = $urandom_range(50, 0);
          end else begin
            xq     = X_W'(cursor);
            cursor = cursor + $urandom_range(32'(step_max), 1);
          end
          yv = full_y ? $urandom : $signed($urandom_range(32'h0010_0000, 0)) - 32'sh0008_0000;
          issue(CMD_LOAD, IDX_W'(i), xq, yv, 1'b0, NO_ANSWER);
          idle_sender();
        end
      end

      queries = (n > 64) ? 30 : $urandom_range(60, 20);
      while (queries > 0) begin
        pick = $urandom_range(19, 0);
        if (pick < 2) begin
          // Stray load: may land inside the active table and break its order.
          yv = $urandom;
          issue(CMD_LOAD, IDX_W'($urandom_range(255, 0)), $urandom, yv, 1'b0, NO_ANSWER);
        end else begin
          case (pick)
            2, 3: xq = (bp_x[0] != 0) ? $urandom_range(bp_x[0] - 1, 0) : '0;
            4, 5: xq = $urandom_range(32'hFFFF_FFFF, bp_x[n-1]);
            6, 7: xq = bp_x[$urandom_range(n - 1, 0)];
            8:    xq = $urandom;
            default: begin
              i  = $urandom_range(n - 2, 0);
              lo = bp_x[i];
              hi = bp_x[i+1];
              xq = (lo < hi) ? $urandom_range(hi - 1, lo) : lo;
            end
          endcase
          issue(CMD_QUERY, IDX_W'($urandom_range(255, 0)), xq, $urandom, 1'b0, NO_ANSWER);
          queries--;
        end
        if ($urandom_range(39, 0) == 0) drain_results();
        idle_sender();
      end
      phase++;
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
src/tli_pkg.sv
src/tli_ram.sv
src/tli_ctrl.sv
src/tli_dp.sv
src/table_linear_interpolator_core.sv
src/tli_checker.sv
test/table_linear_interpolator_core_test.sv
